// ===== hw/rtl/bf3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter: transaction payloads,
// configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package bf3_pkg;

  // field widths of the transaction payloads
  localparam int PIX_W    = 16;
  localparam int MEAN_W   = 20;
  localparam int CCOL_W   = 10;
  localparam int CROW_W   = 12;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int LW_REG_W   = 11;
  localparam int FH_REG_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  // register reset values and legal ranges
  localparam logic [LW_REG_W-1:0] LW_RESET   = 11'd10;
  localparam logic [FH_REG_W-1:0] FH_RESET   = 13'd10;
  localparam logic [FH_REG_W-1:0] MIN_SIZE_H = 13'd3;
  localparam logic [FH_REG_W-1:0] MAX_HEIGHT = 13'd4096;

  // input transaction
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic [CCOL_W-1:0] center_column;
    logic [CROW_W-1:0] center_row;
    logic              frame_last;
  } out_t;

endpackage

// ===== hw/rtl/box_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3
// 3x3 mean filter over a raster-order pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock while not stalled and gives one result
// for every pixel at row 2 or later and column 2 or later: the mean of the 3x3
// window centred one row up and one column left, as unsigned fixed point with 4
// fraction bits, truncated. A result passes the line buffer read, window sum,
// reciprocal multiply and output register; the sustained rate of one pixel per
// cycle without output stalls comes from the line buffer memory doing one read
// and one write each cycle, with a bypass when a pixel reads the entry that the
// pixel before it is writing. The line buffer needs no clearing pass after
// reset; the first two rows of a frame only fill it. Configuration changes
// take effect at once and are meant to be written between frames.
module box_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bf3_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bf3_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // pixel bits in use, counter and arithmetic widths
  localparam int PW     = (PIXEL_BITS < bf3_pkg::PIX_W) ? PIXEL_BITS : bf3_pkg::PIX_W;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CMPW   = (CW + 1 > bf3_pkg::LW_REG_W) ? CW + 1 : bf3_pkg::LW_REG_W;
  localparam int SUM_W  = PW + 4;
  localparam int SH     = PW + 12;
  localparam int PROD_W = SUM_W + SH;
  localparam int AVG_W  = PW + 4;
  localparam logic [SH-1:0]   MUL_K = SH'(((64'd1 << SH) + 64'd8) / 64'd9);
  localparam logic [CMPW-1:0] W_MIN = CMPW'(3);
  localparam logic [CMPW-1:0] W_MAX = CMPW'(MAX_WIDTH);

  // configuration registers
  logic [bf3_pkg::LW_REG_W-1:0] lw_r;
  logic [bf3_pkg::FH_REG_W-1:0] fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= bf3_pkg::LW_RESET;
      fh_r <= bf3_pkg::FH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bf3_pkg::CFG_LINE_WIDTH) begin
        lw_r <= cfg_wdata[bf3_pkg::LW_REG_W-1:0];
      end else if (cfg_index == bf3_pkg::CFG_FRAME_HEIGHT) begin
        fh_r <= cfg_wdata[bf3_pkg::FH_REG_W-1:0];
      end
    end
  end

  // clamped frame size
  logic [CMPW-1:0]              w_eff;
  logic [bf3_pkg::FH_REG_W-1:0] h_eff;

  always_comb begin
    w_eff = CMPW'(lw_r);
    if (w_eff < W_MIN) w_eff = W_MIN;
    if (w_eff > W_MAX) w_eff = W_MAX;
    h_eff = fh_r;
    if (h_eff < bf3_pkg::MIN_SIZE_H) h_eff = bf3_pkg::MIN_SIZE_H;
    if (h_eff > bf3_pkg::MAX_HEIGHT) h_eff = bf3_pkg::MAX_HEIGHT;
  end

  // pipeline valid bits and handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic s1_res_r;
  logic out_ready, s3_ready, s2_ready, s1_fire, accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_v_r || out_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_fire   = s1_v_r && (!s1_res_r || s2_ready);
  assign in_stall  = s1_v_r && !s1_fire;
  assign accept    = in_valid && !in_stall;

  // position counters
  logic [CW-1:0]              col_r;
  logic [bf3_pkg::CROW_W-1:0] row_r;
  logic [CW-1:0]              c_cur;
  logic [bf3_pkg::CROW_W-1:0] r_cur;
  logic [CMPW-1:0]            c_inc;
  logic [bf3_pkg::FH_REG_W-1:0] r_inc;
  logic                       col_wrap, row_wrap, has_res, is_last;

  always_comb begin
    c_cur    = in_data.frame_start ? '0 : col_r;
    r_cur    = in_data.frame_start ? '0 : row_r;
    c_inc    = CMPW'(c_cur) + CMPW'(1);
    r_inc    = bf3_pkg::FH_REG_W'(r_cur) + bf3_pkg::FH_REG_W'(1);
    col_wrap = (c_inc >= w_eff);
    row_wrap = (r_inc >= h_eff);
    has_res  = (r_cur >= bf3_pkg::CROW_W'(2)) && (c_cur >= CW'(2));
    is_last  = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : r_inc[bf3_pkg::CROW_W-1:0];
      end else begin
        col_r <= c_inc[CW-1:0];
        row_r <= r_cur;
      end
    end
  end

  // stage 1 payload: pixel waiting for its line buffer entry
  logic [PW-1:0]              s1_pix_r;
  logic [CW-1:0]              s1_col_r;
  logic [bf3_pkg::CCOL_W-1:0] s1_ccol_r;
  logic [bf3_pkg::CROW_W-1:0] s1_crow_r;
  logic                       s1_last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_data.pixel[PW-1:0];
      s1_col_r  <= c_cur;
      s1_res_r  <= has_res;
      s1_ccol_r <= bf3_pkg::CCOL_W'(c_cur - CW'(1));
      s1_crow_r <= r_cur - bf3_pkg::CROW_W'(1);
      s1_last_r <= is_last;
    end
  end

  // line buffer: entry per column holds {row above mid, previous row}
  logic [2*PW-1:0] lb_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_r;
  logic [2*PW-1:0] fwd_data_r;
  logic            fwd_r;
  logic [2*PW-1:0] lb_cur;
  logic [PW-1:0]   top_px, mid_px;
  logic [2*PW-1:0] wr_data;

  assign lb_cur  = fwd_r ? fwd_data_r : rd_r;
  assign top_px  = lb_cur[2*PW-1:PW];
  assign mid_px  = lb_cur[PW-1:0];
  assign wr_data = {mid_px, s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      lb_mem[s1_col_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= lb_mem[c_cur];
    end
  end

  // bypass when the next pixel reads the entry written this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept) begin
      fwd_r <= s1_fire && (s1_col_r == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= wr_data;
    end
  end

  // 3x3 window: index row*3+col, column 2 newest
  logic [PW-1:0]    win_r   [9];
  logic [PW-1:0]    win_nxt [9];
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]   = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = top_px;
    win_nxt[5] = mid_px;
    win_nxt[8] = s1_pix_r;
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      sum_nxt = sum_nxt + SUM_W'(win_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
  end

  // stage 2: window sum
  logic [SUM_W-1:0]           s2_sum_r;
  logic [bf3_pkg::CCOL_W-1:0] s2_ccol_r;
  logic [bf3_pkg::CROW_W-1:0] s2_crow_r;
  logic                       s2_last_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_sum_r  <= sum_nxt;
      s2_ccol_r <= s1_ccol_r;
      s2_crow_r <= s1_crow_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: multiply by the reciprocal of 9
  logic [PROD_W-1:0]          s3_prod_r;
  logic [bf3_pkg::CCOL_W-1:0] s3_ccol_r;
  logic [bf3_pkg::CROW_W-1:0] s3_crow_r;
  logic                       s3_last_r;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_prod_r <= PROD_W'(s2_sum_r) * PROD_W'(MUL_K);
      s3_ccol_r <= s2_ccol_r;
      s3_crow_r <= s2_crow_r;
      s3_last_r <= s2_last_r;
    end
  end

  // output register: floor(sum * 16 / 9)
  bf3_pkg::out_t out_data_r;
  logic [AVG_W-1:0] avg;

  assign avg = s3_prod_r[SH-4 +: AVG_W];

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data_r.mean_value    <= bf3_pkg::MEAN_W'(avg);
      out_data_r.center_column <= s3_ccol_r;
      out_data_r.center_row    <= s3_crow_r;
      out_data_r.frame_last    <= s3_last_r;
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall)  s1_v_r      <= accept;
      if (s2_ready)   s2_v_r      <= s1_fire && s1_res_r;
      if (s3_ready)   s3_v_r      <= s2_v_r;
      if (out_ready)  out_valid_r <= s3_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // column counter stays inside the line buffer
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(col_r) < W_MAX)
    else $error("column counter beyond line buffer depth");

  // an accepted pixel always lands in stage 1
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted pixel lost before line buffer stage");

  // bypass only follows a line buffer write
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_r) |-> $past(s1_fire))
    else $error("bypass set without a line buffer write");

  // a blocked sum is held in stage 2
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_ready) |=> (s2_v_r && $stable(s2_sum_r)))
    else $error("stage 2 sum dropped while blocked");

endmodule
